FILE: hdl/color_map_lookup_lerp_core_assert.svh
// Assertion macros for the colormap lookup core; expect clk and arst_n in scope.
`ifndef COLOR_MAP_LOOKUP_LERP_CORE_ASSERT_SVH
`define COLOR_MAP_LOOKUP_LERP_CORE_ASSERT_SVH

// same-cycle implication
`define CMLL_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cmll assertion failed");

// next-cycle implication
`define CMLL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cmll assertion failed");

`endif

FILE: hdl/cmll_pkg.sv
// Shared constants and types of the colormap lookup core.
`default_nettype none
package cmll_pkg;

	localparam int TABLE_DEPTH_DEF = 256;

	localparam int SAMPLE_W = 16;
	localparam int INDEX_W  = 8;
	localparam int COLOR_W  = 32;
	localparam int CHAN_W   = 8;
	localparam int SCALE_W  = 24;
	localparam int RES_W    = 9;
	localparam int FRAC_W   = 16;
	localparam int POS_W    = SAMPLE_W + SCALE_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_MAP   = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_VALUE      = 3'd0,
		REG_MAX_VALUE      = 3'd1,
		REG_POSITION_SCALE = 3'd2,
		REG_RESOLUTION     = 3'd3,
		REG_INTERPOLATE    = 3'd4
	} cfg_reg_t;

	localparam logic signed [SAMPLE_W-1:0] MIN_VALUE_RST = 16'sd0;
	localparam logic signed [SAMPLE_W-1:0] MAX_VALUE_RST = 16'sd32767;
	localparam logic [SCALE_W-1:0]         SCALE_RST     = 24'd0;
	localparam logic [RES_W-1:0]           RES_RST       = 9'd256;
	localparam logic                       INTERP_RST    = 1'b1;

endpackage
`default_nettype wire

FILE: hdl/cmll_if.sv
// Valid/ready channel interfaces of the colormap lookup core.
`default_nettype none
interface cmll_in_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   op;
	logic signed [cmll_pkg::SAMPLE_W-1:0]   sample;
	logic [cmll_pkg::INDEX_W-1:0]           entry_index;
	logic [cmll_pkg::COLOR_W-1:0]           entry_color;

	modport source (output valid, op, sample, entry_index, entry_color, input ready);
	modport sink (input valid, op, sample, entry_index, entry_color, output ready);
endinterface

interface cmll_out_if;
	logic                          valid;
	logic                          ready;
	logic [cmll_pkg::CHAN_W-1:0]   red;
	logic [cmll_pkg::CHAN_W-1:0]   green;
	logic [cmll_pkg::CHAN_W-1:0]   blue;
	logic [cmll_pkg::CHAN_W-1:0]   alpha;
	logic                          below_range;
	logic                          above_range;

	modport source (output valid, red, green, blue, alpha, below_range, above_range,
		input ready);
	modport sink (input valid, red, green, blue, alpha, below_range, above_range,
		output ready);
endinterface

interface cmll_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [cmll_pkg::CFG_IDX_W-1:0]    index;
	logic [cmll_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/cmll_table.sv
// Color table: one write port, two registered read ports.
`default_nettype none
module cmll_table #(
	parameter int DEPTH  = cmll_pkg::TABLE_DEPTH_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [ADDR_W-1:0]             waddr,
	input  logic [cmll_pkg::COLOR_W-1:0]  wdata,
	input  logic                          re,
	input  logic [ADDR_W-1:0]             raddr0,
	input  logic [ADDR_W-1:0]             raddr1,
	output logic [cmll_pkg::COLOR_W-1:0]  rdata0,
	output logic [cmll_pkg::COLOR_W-1:0]  rdata1
);

	logic [cmll_pkg::COLOR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while the read stage is stalled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/color_map_lookup_lerp_core.sv
// Throughput: one item per cycle unless the output stalls; an input transfer and its result
// transfer are separated by four register stages (offset, multiply, table read, blend).
// Table writes land at the read stage, so later lookups always see them; writes give no result.
// Reset (arst_n low) clears valid bits and loads config registers with their defaults.
// The color table is not cleared at reset; entries must be written before use.
// Config port is always ready and takes effect at once; write it only while the core is idle.
`default_nettype none
`include "color_map_lookup_lerp_core_assert.svh"
module color_map_lookup_lerp_core #(
	parameter int TABLE_DEPTH = cmll_pkg::TABLE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	cmll_in_if.sink       item,
	cmll_out_if.source    result,
	cmll_cfg_if.sink      cfg
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	// index compare width, wide enough for entry_index and for TABLE_DEPTH itself
	localparam int XW = (CW > cmll_pkg::INDEX_W) ? CW : cmll_pkg::INDEX_W;
	localparam int PW = cmll_pkg::POS_W;
	localparam int IW = PW - cmll_pkg::FRAC_W;  // integer part of the position

	// ---------------- configuration registers ----------------
	logic signed [cmll_pkg::SAMPLE_W-1:0] min_q;
	logic signed [cmll_pkg::SAMPLE_W-1:0] max_q;
	logic [cmll_pkg::SCALE_W-1:0]         scale_q;
	logic [cmll_pkg::RES_W-1:0]           res_q;
	logic                                 interp_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q    <= cmll_pkg::MIN_VALUE_RST;
			max_q    <= cmll_pkg::MAX_VALUE_RST;
			scale_q  <= cmll_pkg::SCALE_RST;
			res_q    <= cmll_pkg::RES_RST;
			interp_q <= cmll_pkg::INTERP_RST;
		end else if (cfg.valid) begin
			case (cmll_pkg::cfg_reg_t'(cfg.index))
				cmll_pkg::REG_MIN_VALUE: begin
					min_q <= cfg.data[cmll_pkg::SAMPLE_W-1:0];
				end
				cmll_pkg::REG_MAX_VALUE: begin
					max_q <= cfg.data[cmll_pkg::SAMPLE_W-1:0];
				end
				cmll_pkg::REG_POSITION_SCALE: begin
					scale_q <= cfg.data[cmll_pkg::SCALE_W-1:0];
				end
				cmll_pkg::REG_RESOLUTION: begin
					res_q <= cfg.data[cmll_pkg::RES_W-1:0];
				end
				cmll_pkg::REG_INTERPOLATE: begin
					interp_q <= cfg.data[0];
				end
				default: begin
					// unknown index: dropped
				end
			endcase
		end
	end

	// last entry in use: resolution clamped to 2..TABLE_DEPTH, minus one
	logic [IW-1:0] res_ext;
	logic [IW-1:0] depth_ext;
	logic [IW-1:0] last_idx;

	always_comb begin
		res_ext   = IW'(res_q);
		depth_ext = IW'(TABLE_DEPTH);
		if (res_ext < IW'(2)) begin
			last_idx = IW'(1);
		end else if (res_ext > depth_ext) begin
			last_idx = depth_ext - IW'(1);
		end else begin
			last_idx = res_ext - IW'(1);
		end
	end

	// ---------------- stage handshake ----------------
	// each stage moves when it is empty or the stage after it moves,
	// so bubbles fill up even while the output is stalled
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || result.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign item.ready = en1;

	// ---------------- stage 1: offset from minimum, range flags ----------------
	logic [cmll_pkg::SAMPLE_W:0]   diff_nxt;
	logic [cmll_pkg::SAMPLE_W-1:0] dpos_nxt;
	logic                          below_nxt;
	logic                          above_nxt;

	always_comb begin
		diff_nxt  = {item.sample[cmll_pkg::SAMPLE_W-1], item.sample}
			- {min_q[cmll_pkg::SAMPLE_W-1], min_q};
		// only a positive offset yields a position
		dpos_nxt  = (!diff_nxt[cmll_pkg::SAMPLE_W] && (diff_nxt != '0))
			? diff_nxt[cmll_pkg::SAMPLE_W-1:0] : '0;
		below_nxt = (item.sample <= min_q);
		above_nxt = (item.sample >= max_q);
	end

	logic                          op_s1;
	logic [cmll_pkg::SAMPLE_W-1:0] dpos_s1;
	logic                          below_s1, above_s1;
	logic [cmll_pkg::INDEX_W-1:0]  index_s1;
	logic [cmll_pkg::COLOR_W-1:0]  color_s1;

	// ---------------- stage 2: Q16 position ----------------
	logic                          op_s2;
	logic [PW-1:0]                 pos_s2;
	logic                          below_s2, above_s2;
	logic [cmll_pkg::INDEX_W-1:0]  index_s2;
	logic [cmll_pkg::COLOR_W-1:0]  color_s2;

	// ---------------- stage 3: entry select and table read ----------------
	logic [IW-1:0]                 idx_int;
	logic [IW-1:0]                 sel_idx;
	logic                          blend_nxt;
	logic [cmll_pkg::FRAC_W-1:0]   frac_nxt;
	logic                          above_sel;
	logic [AW-1:0]                 rd_addr0, rd_addr1;
	logic                          tbl_re, tbl_we;
	logic [XW-1:0]                 wr_idx_ext;

	always_comb begin
		idx_int   = pos_s2[PW-1:cmll_pkg::FRAC_W];
		sel_idx   = idx_int;
		blend_nxt = 1'b0;
		above_sel = above_s2;
		if (!interp_q) begin
			// entry at the integer part of the position, clamped to the last one in use
			if (idx_int > last_idx) begin
				sel_idx   = last_idx;
				above_sel = 1'b1;
			end
		end else if (below_s2) begin
			// checked before the upper bound: entry 0 wins if min >= max
			sel_idx = '0;
		end else if (above_s2) begin
			sel_idx = last_idx;
		end else if (idx_int >= last_idx) begin
			// no right neighbor left to blend with
			sel_idx   = last_idx;
			above_sel = 1'b1;
		end else begin
			blend_nxt = 1'b1;
		end
		// zero weight on the second entry gives the first one unchanged
		frac_nxt = blend_nxt ? pos_s2[cmll_pkg::FRAC_W-1:0] : '0;
		rd_addr0 = sel_idx[AW-1:0];
		rd_addr1 = blend_nxt ? (rd_addr0 + AW'(1)) : rd_addr0;
	end

	assign wr_idx_ext = XW'(index_s2);
	assign tbl_re = en3 && v_s2 && (op_s2 == cmll_pkg::OP_MAP);
	// out-of-table writes are dropped
	assign tbl_we = en3 && v_s2 && (op_s2 == cmll_pkg::OP_WRITE)
		&& (wr_idx_ext < XW'(TABLE_DEPTH));

	logic [cmll_pkg::COLOR_W-1:0]  rdata0_s3, rdata1_s3;
	logic [cmll_pkg::FRAC_W-1:0]   frac_s3;
	logic                          below_s3, above_s3;

	cmll_table #(
		.DEPTH  (TABLE_DEPTH),
		.ADDR_W (AW)
	) u_table (
		.clk    (clk),
		.we     (tbl_we),
		.waddr  (wr_idx_ext[AW-1:0]),
		.wdata  (color_s2),
		.re     (tbl_re),
		.raddr0 (rd_addr0),
		.raddr1 (rd_addr1),
		.rdata0 (rdata0_s3),
		.rdata1 (rdata1_s3)
	);

	// ---------------- stage 4: per-channel blend ----------------
	// a*(1-f) + b*f == a + (b-a)*f, truncated; result always fits a byte
	localparam int LANES = cmll_pkg::COLOR_W / cmll_pkg::CHAN_W;
	localparam int ACC_W = cmll_pkg::CHAN_W + cmll_pkg::FRAC_W + 2;

	logic [cmll_pkg::CHAN_W-1:0]        lane_a   [LANES];
	logic [cmll_pkg::CHAN_W-1:0]        lane_b   [LANES];
	logic signed [cmll_pkg::CHAN_W:0]   lane_d   [LANES];
	logic signed [ACC_W-1:0]            lane_acc [LANES];
	logic [cmll_pkg::COLOR_W-1:0]       color_nxt;

	always_comb begin
		color_nxt = '0;
		for (int k = 0; k < LANES; k++) begin
			lane_a[k]   = rdata0_s3[k*cmll_pkg::CHAN_W +: cmll_pkg::CHAN_W];
			lane_b[k]   = rdata1_s3[k*cmll_pkg::CHAN_W +: cmll_pkg::CHAN_W];
			lane_d[k]   = $signed({1'b0, lane_b[k]}) - $signed({1'b0, lane_a[k]});
			lane_acc[k] = $signed({2'b00, lane_a[k], {cmll_pkg::FRAC_W{1'b0}}})
				+ lane_d[k] * $signed({1'b0, frac_s3});
			color_nxt[k*cmll_pkg::CHAN_W +: cmll_pkg::CHAN_W] =
				lane_acc[k][cmll_pkg::FRAC_W +: cmll_pkg::CHAN_W];
		end
	end

	logic [cmll_pkg::COLOR_W-1:0] color_s4;
	logic                         below_s4, above_s4;

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= item.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				// write items retire here
				v_s3 <= v_s2 && (op_s2 == cmll_pkg::OP_MAP);
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// ---------------- payload ----------------
	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1    <= item.op;
			dpos_s1  <= dpos_nxt;
			below_s1 <= below_nxt;
			above_s1 <= above_nxt;
			index_s1 <= item.entry_index;
			color_s1 <= item.entry_color;
		end
		if (en2) begin
			op_s2    <= op_s1;
			pos_s2   <= PW'(dpos_s1) * PW'(scale_q);
			below_s2 <= below_s1;
			above_s2 <= above_s1;
			index_s2 <= index_s1;
			color_s2 <= color_s1;
		end
		if (en3) begin
			frac_s3  <= frac_nxt;
			below_s3 <= below_s2;
			above_s3 <= above_sel;
		end
		if (en4) begin
			color_s4 <= color_nxt;
			below_s4 <= below_s3;
			above_s4 <= above_s3;
		end
	end

	assign result.valid       = v_s4;
	assign result.red         = color_s4[31:24];
	assign result.green       = color_s4[23:16];
	assign result.blue        = color_s4[15:8];
	assign result.alpha       = color_s4[7:0];
	assign result.below_range = below_s4;
	assign result.above_range = above_s4;

	// ---------------- assertions ----------------
	// input only backs up when every stage is full and the output is stalled
	`CMLL_ASSERT(a_stall_only_when_full, !item.ready, v_s1 && v_s2 && v_s3 && v_s4 && !result.ready)
	// reads stay within the entries in use
	`CMLL_ASSERT(a_read_in_use, tbl_re, IW'(rd_addr0) <= last_idx && IW'(rd_addr1) <= last_idx)
	// a nonzero weight always pairs an entry with its right neighbor
	`CMLL_ASSERT(a_blend_adjacent, tbl_re && (frac_nxt != '0), rd_addr1 == rd_addr0 + AW'(1))
	// a write item never yields a result
	`CMLL_ASSERT_NEXT(a_write_no_result, en3 && v_s2 && (op_s2 == cmll_pkg::OP_WRITE), !v_s3)

endmodule
`default_nettype wire
